// File: hw/rtl/brl_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; imported by brl_front, brl_stepper, brl_addr and the top level.
package brl_pkg;

  // Input item kinds, carried in s_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BYTES_PIXEL  = 2'd3;

  // Field widths that do not follow the coordinate size
  localparam int DIM_W    = 12;
  localparam int STRIDE_W = 14;
  localparam int BPP_W    = 3;
  localparam int CFG_W    = 14;
  localparam int COLOR_W  = 32;
  localparam int OFF_W    = 24;
  localparam int PROD_W   = 32;
  localparam int BYTE_BITS = 8;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 12'd1024;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 12'd768;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 14'd4096;
  localparam logic [BPP_W-1:0]    RST_BYTES_PIXEL  = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [STRIDE_W-1:0] row_stride_bytes;
    logic [BPP_W-1:0]    bytes_per_pixel;
  } cfg_t;

endpackage

// File: hw/rtl/brl_cmd_fifo.sv
// Small register queue carrying decoded commands from front to back.
// Depends on nothing; depth must be a power of two.
module brl_cmd_fifo #(
  parameter int W     = 109,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/brl_front.sv
// Front end: accepts input transfers, decodes start commands into line setup.
// Depends on brl_pkg; feeds brl_cmd_fifo.
module brl_front #(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = 80,
  parameter int CMD_W      = 109
) (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,
  input  logic             fifo_full,
  output logic             push,
  output logic [CMD_W-1:0] push_data
);
  import brl_pkg::*;

  localparam int P = COORD_BITS;

  logic [P-1:0]       x0, y0, x1, y1;
  logic [COLOR_W-1:0] color;
  logic [P:0]         dx_s, dy_s;
  logic [P:0]         abs_dx, neg_abs_dy;
  logic               dir_x_neg, dir_y_neg;

  // Unpack the payload
  assign x0    = s_tdata[P-1:0];
  assign y0    = s_tdata[2*P-1:P];
  assign x1    = s_tdata[3*P-1:2*P];
  assign y1    = s_tdata[4*P-1:3*P];
  assign color = s_tdata[4*P+COLOR_W-1:4*P];

  // Signed differences and step directions
  assign dx_s = {x1[P-1], x1} - {x0[P-1], x0};
  assign dy_s = {y1[P-1], y1} - {y0[P-1], y0};
  assign abs_dx     = dx_s[P] ? ((P+1)'(0) - dx_s) : dx_s;
  assign neg_abs_dy = dy_s[P] ? dy_s : ((P+1)'(0) - dy_s);
  assign dir_x_neg  = dx_s[P] || (dx_s == '0);
  assign dir_y_neg  = dy_s[P] || (dy_s == '0);

  // Accept while the queue has room
  assign s_tready  = !fifo_full;
  assign push      = s_tvalid && s_tready;
  assign push_data = {color, neg_abs_dy, abs_dx, dir_y_neg, dir_x_neg,
                      y1, x1, y0, x0, s_tuser};

endmodule

// File: hw/rtl/brl_stepper.sv
// Back end: Bresenham error stepper, one point per tick command while a line is in progress.
// Depends on brl_pkg; pops brl_cmd_fifo and feeds brl_addr.
module brl_stepper #(
  parameter int COORD_BITS = 12,
  parameter int CMD_W      = 109
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic [CMD_W-1:0]   cmd_data,
  output logic               cmd_pop,
  output logic               pix_valid,
  input  logic               pix_ready,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic [brl_pkg::COLOR_W-1:0] pix_color,
  output logic               pix_last
);
  import brl_pkg::*;

  localparam int P     = COORD_BITS;
  localparam int ERR_W = P + 3;

  // Decoded command fields
  logic               c_kind;
  logic [P-1:0]       c_x0, c_y0, c_x1, c_y1;
  logic               c_dirx, c_diry;
  logic [P:0]         c_dx, c_ndy;
  logic [COLOR_W-1:0] c_color;

  assign {c_color, c_ndy, c_dx, c_diry, c_dirx, c_y1, c_x1, c_y0, c_x0, c_kind} = cmd_data;

  // Line state
  logic               busy;
  logic [P-1:0]       cur_x, cur_y, tgt_x, tgt_y;
  logic               dir_x_neg, dir_y_neg;
  logic [P:0]         delta_x, neg_delta_y;
  logic [ERR_W-1:0]   error_term;
  logic [COLOR_W-1:0] held_color;

  logic             slot_free, emit, fin;
  logic [ERR_W:0]   twice, dx_w, ndy_w;
  logic             step_x, step_y;
  logic [ERR_W-1:0] error_next;
  logic [P-1:0]     cur_x_next, cur_y_next;

  assign slot_free = !pix_valid || pix_ready;
  assign cmd_pop   = cmd_valid && ((c_kind == OP_START) || !busy || slot_free);
  assign emit      = cmd_pop && (c_kind == OP_TICK) && busy;
  assign fin       = (cur_x == tgt_x) && (cur_y == tgt_y);

  // Error test and coordinate step
  assign twice  = {error_term, 1'b0};
  assign dx_w   = {{3{delta_x[P]}}, delta_x};
  assign ndy_w  = {{3{neg_delta_y[P]}}, neg_delta_y};
  assign step_x = $signed(twice) >= $signed(ndy_w);
  assign step_y = $signed(twice) <= $signed(dx_w);
  assign error_next = error_term + (step_x ? ndy_w[ERR_W-1:0] : '0)
                                 + (step_y ? dx_w[ERR_W-1:0] : '0);
  assign cur_x_next = step_x ? (cur_x + (dir_x_neg ? {P{1'b1}} : P'(1))) : cur_x;
  assign cur_y_next = step_y ? (cur_y + (dir_y_neg ? {P{1'b1}} : P'(1))) : cur_y;

  // Load a new line or advance the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      tgt_x       <= '0;
      tgt_y       <= '0;
      dir_x_neg   <= 1'b0;
      dir_y_neg   <= 1'b0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      error_term  <= '0;
      held_color  <= '0;
    end else if (cmd_pop && (c_kind == OP_START)) begin
      busy        <= 1'b1;
      cur_x       <= c_x0;
      cur_y       <= c_y0;
      tgt_x       <= c_x1;
      tgt_y       <= c_y1;
      dir_x_neg   <= c_dirx;
      dir_y_neg   <= c_diry;
      delta_x     <= c_dx;
      neg_delta_y <= c_ndy;
      error_term  <= {{2{c_dx[P]}}, c_dx} + {{2{c_ndy[P]}}, c_ndy};
      held_color  <= c_color;
    end else if (emit) begin
      if (fin) begin
        busy <= 1'b0;
      end else begin
        error_term <= error_next;
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
      end
    end
  end

  // Hold the emitted point until the next stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x     <= cur_x;
      pix_y     <= cur_y;
      pix_color <= held_color;
      pix_last  <= fin;
    end
  end

endmodule

// File: hw/rtl/brl_addr.sv
// Back end output path: bounds test, byte offset products and output register.
// Depends on brl_pkg; takes points from brl_stepper.
module brl_addr #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brl_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COORD_BITS-1:0]       in_x,
  input  logic [COORD_BITS-1:0]       in_y,
  input  logic [brl_pkg::COLOR_W-1:0] in_color,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COORD_BITS-1:0]       out_x,
  output logic [COORD_BITS-1:0]       out_y,
  output logic [brl_pkg::COLOR_W-1:0] out_color,
  output logic [brl_pkg::OFF_W-1:0]   out_offset,
  output logic                        out_visible,
  output logic                        out_last
);
  import brl_pkg::*;

  localparam int P  = COORD_BITS;
  localparam int CW = (P > DIM_W) ? P : DIM_W;

  logic              vis;
  logic [PROD_W-1:0] prod_y, prod_x;

  logic               a_valid, a_vis, a_last;
  logic [P-1:0]       a_x, a_y;
  logic [COLOR_W-1:0] a_color;
  logic [OFF_W-1:0]   a_prod_y, a_prod_x;
  logic               a_ready, b_ready;

  // Point lies inside the image
  assign vis = !in_x[P-1] && !in_y[P-1] &&
               (CW'(in_x) < CW'(cfg.image_width)) &&
               (CW'(in_y) < CW'(cfg.image_height));

  assign prod_y = PROD_W'(cfg.row_stride_bytes) * PROD_W'(in_y);
  assign prod_x = PROD_W'(cfg.bytes_per_pixel) * PROD_W'(in_x);

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A: bounds and partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_x      <= in_x;
      a_y      <= in_y;
      a_color  <= in_color;
      a_last   <= in_last;
      a_vis    <= vis;
      a_prod_y <= prod_y[OFF_W-1:0];
      a_prod_x <= prod_x[OFF_W-1:0];
    end
  end

  // Stage B: sum the offset, zero it off screen
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_x       <= a_x;
      out_y       <= a_y;
      out_color   <= a_color;
      out_last    <= a_last;
      out_visible <= a_vis;
      out_offset  <= a_vis ? (a_prod_y + a_prod_x) : '0;
    end
  end

endmodule

// File: hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer, top level: ports, configuration registers, assembly.
// Depends on brl_pkg, brl_front, brl_cmd_fifo, brl_stepper and brl_addr.
//
// A start item (s_tuser = 0) loads both endpoints and the color and produces
// nothing; each tick item (s_tuser = 1) produces one pixel while a line is in
// progress and nothing when idle. Unless the output stalls, the block accepts
// one item per clock and delivers one pixel per clock: the stepper's error
// update and coordinate step are combinational. A pixel passes through the
// command queue, stepper output register, product stage and offset sum before
// it reaches the output. A four-entry command queue lets input keep flowing
// while the output stalls, until it fills. The last pixel of a line carries
// tlast; tuser marks pixels inside the image, and the byte offset is zero for
// those outside. Configuration writes are meant for idle periods only.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  // Input stream
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata, low bit up: start_x, start_y, end_x, end_y, line_color, zero fill
  input  logic [((4*COORD_BITS+brl_pkg::COLOR_W+brl_pkg::BYTE_BITS-1)
                 /brl_pkg::BYTE_BITS)*brl_pkg::BYTE_BITS-1:0] s_tdata,
  // s_tuser: opcode
  input  logic s_tuser,
  // Output stream
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata, low bit up: pixel_x, pixel_y, pixel_color, byte_offset, zero fill
  output logic [((2*COORD_BITS+brl_pkg::COLOR_W+brl_pkg::OFF_W+brl_pkg::BYTE_BITS-1)
                 /brl_pkg::BYTE_BITS)*brl_pkg::BYTE_BITS-1:0] m_tdata,
  // m_tuser: visible
  output logic m_tuser,
  output logic m_tlast,
  // Configuration write port
  input  logic                            cfg_wr_en,
  input  logic [brl_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [brl_pkg::CFG_W-1:0]       cfg_data
);
  import brl_pkg::*;

  localparam int P      = COORD_BITS;
  localparam int IN_W   = ((4*P + COLOR_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
  localparam int OUT_W  = ((2*P + COLOR_W + OFF_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
  localparam int CMD_W  = 6*P + 37;

  cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width      <= RST_IMAGE_WIDTH;
      cfg.image_height     <= RST_IMAGE_HEIGHT;
      cfg.row_stride_bytes <= RST_ROW_STRIDE;
      cfg.bytes_per_pixel  <= RST_BYTES_PIXEL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width      <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height     <= cfg_data[DIM_W-1:0];
        REG_ROW_STRIDE:   cfg.row_stride_bytes <= cfg_data[STRIDE_W-1:0];
        REG_BYTES_PIXEL:  cfg.bytes_per_pixel  <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  logic             push, fifo_full, pop, cmd_valid;
  logic [CMD_W-1:0] push_data, cmd_data;

  logic               pix_valid, pix_ready, pix_last;
  logic [P-1:0]       pix_x, pix_y;
  logic [COLOR_W-1:0] pix_color;

  logic [P-1:0]       out_x, out_y;
  logic [COLOR_W-1:0] out_color;
  logic [OFF_W-1:0]   out_offset;

  brl_front #(
    .COORD_BITS(P),
    .IN_W      (IN_W),
    .CMD_W     (CMD_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fifo_full(fifo_full),
    .push     (push),
    .push_data(push_data)
  );

  brl_cmd_fifo #(
    .W    (CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (pop),
    .pop_valid(cmd_valid),
    .pop_data (cmd_data)
  );

  brl_stepper #(
    .COORD_BITS(P),
    .CMD_W     (CMD_W)
  ) u_stepper (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_data),
    .cmd_pop  (pop),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .pix_color(pix_color),
    .pix_last (pix_last)
  );

  brl_addr #(
    .COORD_BITS(P)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pix_valid),
    .in_ready   (pix_ready),
    .in_x       (pix_x),
    .in_y       (pix_y),
    .in_color   (pix_color),
    .in_last    (pix_last),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_color  (out_color),
    .out_offset (out_offset),
    .out_visible(m_tuser),
    .out_last   (m_tlast)
  );

  assign m_tdata = OUT_W'({out_offset, out_color, out_y, out_x});

  // Nothing is offered on the output right after reset
  a_no_out_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A visible pixel has non-negative coordinates
  a_visible_nonneg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (!out_x[P-1] && !out_y[P-1]))
    else $error("visible pixel with negative coordinate");

  // An off-screen pixel carries a zero byte offset
  a_hidden_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_offset == '0))
    else $error("hidden pixel with nonzero offset");

endmodule
